// File: hw/rtl/sm3_pkg.sv
// ---------------------------------------------------------------------------
// SM3 package
// Shared types, constants and round functions for the SM3 hash engine.
// ---------------------------------------------------------------------------
package sm3_pkg;

  localparam logic [1:0] FUNC_ABSORB        = 2'd0;
  localparam logic [1:0] FUNC_ABSORB_FINISH = 2'd1;
  localparam logic [1:0] FUNC_FINISH        = 2'd2;

  localparam logic [31:0] T_LOW  = 32'h79CC4519;
  localparam logic [31:0] T_HIGH = 32'h7A879D8A;

  localparam logic [255:0] IV = {32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
                                 32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD,
    ST_PAD,
    ST_LEN,
    ST_EMIT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic absorb;     // pack input byte
    logic load;       // load A..H and window from chain/block
    logic round;      // run one round
    logic fold;       // xor working regs into chain value
    logic pad;        // build padded final block in buffer
    logic len_block;  // build zero block with length only
    logic emit_shift; // advance digest output word
    logic clear;      // return to IV and empty buffer
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic block_full;
    logic two_blocks;
    logic last_byte;  // next absorbed byte completes the block
  } status_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

  function automatic logic [31:0] p0(input logic [31:0] x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic logic [31:0] p1(input logic [31:0] x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction

endpackage

// File: hw/rtl/sm3_ctrl.sv
// ---------------------------------------------------------------------------
// SM3 controller
// Sequences byte absorb, compression rounds, padding and digest output.
// ---------------------------------------------------------------------------
module sm3_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [1:0]       in_func,
  output logic             in_ready,
  input  logic             out_ready,
  output logic             out_valid,
  output logic [2:0]       out_index,
  input  sm3_pkg::status_t status,
  output sm3_pkg::cmd_t    cmd,
  output logic [5:0]       round_idx
);
  import sm3_pkg::*;

  state_t     state, state_next;
  logic [5:0] round_idx_q;
  logic [5:0] round_next;
  logic [2:0] emit_idx, emit_idx_next;
  logic       finishing, finishing_next;
  logic       second, second_next;
  logic       take;

  assign take      = in_valid && in_ready;
  assign round_idx = round_idx_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      round_idx_q <= '0;
      emit_idx    <= '0;
      finishing   <= 1'b0;
      second      <= 1'b0;
    end else begin
      state       <= state_next;
      round_idx_q <= round_next;
      emit_idx    <= emit_idx_next;
      finishing   <= finishing_next;
      second      <= second_next;
    end
  end

  // next state
  always_comb begin
    state_next     = state;
    round_next     = round_idx_q;
    emit_idx_next  = emit_idx;
    finishing_next = finishing;
    second_next    = second;
    unique case (state)
      ST_IDLE: begin
        if (take) begin
          if (in_func == FUNC_ABSORB) begin
            if (status.last_byte) begin
              finishing_next = 1'b0;
              state_next     = ST_LOAD;
            end
          end else if (in_func == FUNC_ABSORB_FINISH) begin
            finishing_next = 1'b1;
            state_next     = status.last_byte ? ST_LOAD : ST_PAD;
          end else if (in_func == FUNC_FINISH) begin
            finishing_next = 1'b1;
            state_next     = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        second_next = status.two_blocks;
        state_next  = ST_LOAD;
      end
      ST_LOAD: begin
        round_next = '0;
        state_next = ST_ROUND;
      end
      ST_ROUND: begin
        round_next = round_idx_q + 6'd1;
        if (round_idx_q == 6'd63) state_next = ST_FOLD;
      end
      ST_FOLD: begin
        if (!finishing) begin
          state_next = ST_IDLE;
        end else if (second) begin
          second_next = 1'b0;
          state_next  = ST_LEN;
        end else if (status.block_full) begin
          // full block from absorb-then-finish: pad next
          state_next = ST_PAD;
        end else begin
          emit_idx_next = '0;
          state_next    = ST_EMIT;
        end
      end
      ST_LEN:  state_next = ST_LOAD;
      ST_EMIT: begin
        if (out_ready) begin
          emit_idx_next = emit_idx + 3'd1;
          if (emit_idx == 3'd7) begin
            finishing_next = 1'b0;
            state_next     = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    out_index = emit_idx;
    unique case (state)
      ST_IDLE:  begin
        in_ready   = 1'b1;
        cmd.absorb = take && (in_func == FUNC_ABSORB || in_func == FUNC_ABSORB_FINISH);
      end
      ST_PAD:   cmd.pad = 1'b1;
      ST_LEN:   cmd.len_block = 1'b1;
      ST_LOAD:  cmd.load = 1'b1;
      ST_ROUND: cmd.round = 1'b1;
      ST_FOLD:  cmd.fold = 1'b1;
      ST_EMIT:  begin
        out_valid      = 1'b1;
        cmd.emit_shift = out_ready;
        cmd.clear      = out_ready && emit_idx == 3'd7;
      end
      default: ;
    endcase
  end

endmodule

// File: hw/rtl/sm3_dpath.sv
// ---------------------------------------------------------------------------
// SM3 datapath
// Block buffer, length counter, expansion window, round unit and chain value.
// ---------------------------------------------------------------------------
module sm3_dpath (
  input  logic              clk,
  input  logic              rst,
  input  sm3_pkg::cmd_t     cmd,
  input  logic [5:0]        round_idx,
  input  logic [7:0]        data_byte,
  output sm3_pkg::status_t  status,
  output logic [31:0]       digest_word
);
  import sm3_pkg::*;

  logic [511:0] blk;       // word 0 in the top bits
  logic [5:0]   fill;
  logic         full;      // block holds 64 bytes awaiting compression
  logic [63:0]  bit_len;
  logic [255:0] chain;
  logic [255:0] work;
  logic [511:0] win;       // W[j..j+15], W[j] in top bits
  logic [255:0] out_sr;

  logic [31:0] a, b, c, d, e, f, g, h, w0, w4, tj, a12, ss1, ss2, ffv, ggv, tt1, tt2;
  logic [31:0] wn;
  logic [511:0] padded;
  logic [8:0]  sh;

  assign {a, b, c, d, e, f, g, h} = work;
  assign w0 = win[511:480];
  assign w4 = win[383:352];

  always_comb begin
    tj  = (round_idx < 6'd16) ? T_LOW : T_HIGH;
    a12 = rotl(a, 5'd12);
    ss1 = rotl(a12 + e + rotl(tj, round_idx[4:0]), 5'd7);
    ss2 = ss1 ^ a12;
    if (round_idx < 6'd16) begin
      ffv = a ^ b ^ c;
      ggv = e ^ f ^ g;
    end else begin
      ffv = (a & b) | (a & c) | (b & c);
      ggv = (e & f) | (~e & g);
    end
    tt1 = ffv + d + ss2 + (w0 ^ w4);
    tt2 = ggv + h + ss1 + w0;
    // next expansion word W[j+16] from window
    wn = p1(win[511:480] ^ win[287:256] ^ rotl(win[95:64], 5'd15))
         ^ rotl(win[415:384], 5'd7) ^ win[191:160];
  end

  // padded block: keep bytes before fill, marker, zeros, length if room
  always_comb begin
    logic [511:0] keep;
    keep   = ~({512{1'b1}} >> {fill, 3'b000});
    sh     = 9'd504 - {fill, 3'b000};
    padded = (blk & keep) | ({504'd0, 8'h80} << sh);
    if (fill < 6'd56) padded[63:0] = bit_len;
  end

  assign status.block_full = full;
  assign status.two_blocks = (fill >= 6'd56);
  assign status.last_byte  = (fill == 6'd63);
  assign digest_word       = out_sr[255:224];

  always_ff @(posedge clk) begin
    if (rst) begin
      fill    <= '0;
      full    <= 1'b0;
      bit_len <= '0;
      chain   <= IV;
      blk     <= '0;
    end else begin
      if (cmd.absorb) begin
        blk     <= (blk & ~({504'd0, 8'hFF} << (9'd504 - {fill, 3'b000})))
                   | ({504'd0, data_byte} << (9'd504 - {fill, 3'b000}));
        fill    <= fill + 6'd1;
        full    <= (fill == 6'd63);
        bit_len <= bit_len + 64'd8;
      end
      if (cmd.pad) blk <= padded;
      if (cmd.len_block) blk <= {448'd0, bit_len};
      if (cmd.fold) begin
        chain <= chain ^ work;
        full  <= 1'b0;
      end
      if (cmd.clear) begin
        chain   <= IV;
        fill    <= '0;
        bit_len <= '0;
        blk     <= '0;
      end else if (cmd.fold) begin
        out_sr <= chain ^ work;
      end
      if (cmd.emit_shift) out_sr <= {out_sr[223:0], 32'd0};
      if (cmd.load) begin
        work <= chain;
        win  <= blk;
      end
      if (cmd.round) begin
        work <= {tt1, a, rotl(b, 5'd9), c, p0(tt2), e, rotl(f, 5'd19), g};
        win  <= {win[479:0], wn};
      end
    end
  end

endmodule

// File: hw/rtl/sm3_hash_engine.sv
// ---------------------------------------------------------------------------
// SM3 hash engine
// Byte-stream SM3 hashing with eight-word digest output per message.
// ---------------------------------------------------------------------------
// Absorb: one byte per cycle while idle; a full block then stalls input for
// compression (one load, 64 rounds on the single round unit, one fold).
// Finish: pad plus one or two compressions (two when the padded tail spills
// over or the finishing byte completes a block), then eight digest words,
// one per cycle when the sink is ready.
// Synchronous reset restores the IV and empties the block buffer.
module sm3_hash_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic [1:0]  s_axis_tuser,   // [1:0] func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_index, zero fill
  output logic        m_axis_tlast
);
  import sm3_pkg::*;

  cmd_t       cmd;
  status_t    status;
  logic [5:0] round_idx;
  logic [2:0] word_index;
  logic [31:0] digest_word;

  sm3_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_func   (s_axis_tuser),
    .in_ready  (s_axis_tready),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_index (word_index),
    .status    (status),
    .cmd       (cmd),
    .round_idx (round_idx)
  );

  sm3_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .round_idx   (round_idx),
    .data_byte   (s_axis_tdata),
    .status      (status),
    .digest_word (digest_word)
  );

  assign m_axis_tdata = {5'd0, word_index, digest_word};
  assign m_axis_tlast = (word_index == 3'd7);

endmodule

// File: hw/rtl/sm3_checker.sv
// ---------------------------------------------------------------------------
// SM3 port checker
// Watches the top-level ports of the hash engine over time.
// ---------------------------------------------------------------------------
module sm3_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // never take input while a digest is being delivered
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid)) else $error("input taken during output");

  // last marks word seven only
  a_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[34:32] == 3'd7)))
    else $error("tlast mismatch");

  // index advances by one after each delivered word
  a_index: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
      (m_axis_tvalid && m_axis_tdata[34:32] == $past(m_axis_tdata[34:32]) + 3'd1))
    else $error("word index skipped");

  // stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("output changed under stall");

endmodule

bind sm3_hash_engine sm3_checker u_sm3_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

// File: tb/tb_sm3_hash_engine.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SM3 hash engine testbench
// Streams message bytes into the engine, hashes every message with an
// independent SM3 model and compares each digest word on the output stream.
// ---------------------------------------------------------------------------
module tb_sm3_hash_engine;
  import sm3_pkg::*;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] data;
  } msg_item_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_beat_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;

  sm3_hash_engine dut (.*);

  msg_item_t    byte_queue[$];
  digest_beat_t digest_queue[$];

  // hashing state of the prediction
  logic [31:0] hash_state[8];
  logic [31:0] pend_words[16];
  logic [5:0]  pend_fill;
  logic [63:0] msg_bits;

  int  errors = 0;
  int  words_seen = 0;
  int  msgs_done = 0;
  int  send_gap = 0;
  int  sink_gap = 0;
  int  hold_cycles = 0;
  bit  quiet = 0;
  bit  pressure_on = 0;
  bit  stim_done = 0;
  int  in_flight_words = 0;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  function automatic logic [31:0] rol(input logic [31:0] x, input int n);
    n = n % 32;
    if (n == 0) return x;
    return (x << n) | (x >> (32 - n));
  endfunction

  task automatic compress(input logic [31:0] blk[16]);
    logic [31:0] w[68];
    logic [31:0] r[8];
    logic [31:0] tj, a12, ss1, ss2, ff, gg, tt1, tt2, t;
    for (int j = 0; j < 16; j++) w[j] = blk[j];
    for (int j = 16; j < 68; j++) begin
      t = w[j-16] ^ w[j-9] ^ rol(w[j-3], 15);
      w[j] = t ^ rol(t, 15) ^ rol(t, 23) ^ rol(w[j-13], 7) ^ w[j-6];
    end
    for (int j = 0; j < 8; j++) r[j] = hash_state[j];
    for (int j = 0; j < 64; j++) begin
      tj = (j < 16) ? T_LOW : T_HIGH;
      a12 = rol(r[0], 12);
      ss1 = rol(a12 + r[4] + rol(tj, j), 7);
      ss2 = ss1 ^ a12;
      if (j < 16) begin
        ff = r[0] ^ r[1] ^ r[2];
        gg = r[4] ^ r[5] ^ r[6];
      end else begin
        ff = (r[0] & r[1]) | (r[0] & r[2]) | (r[1] & r[2]);
        gg = (r[4] & r[5]) | (~r[4] & r[6]);
      end
      tt1 = ff + r[3] + ss2 + (w[j] ^ w[j+4]);
      tt2 = gg + r[7] + ss1 + w[j];
      r[3] = r[2]; r[2] = rol(r[1], 9); r[1] = r[0]; r[0] = tt1;
      r[7] = r[6]; r[6] = rol(r[5], 19); r[5] = r[4];
      r[4] = tt2 ^ rol(tt2, 9) ^ rol(tt2, 17);
    end
    for (int j = 0; j < 8; j++) hash_state[j] ^= r[j];
  endtask

  task automatic clear_hash();
    for (int j = 0; j < 8; j++) hash_state[j] = IV[255 - 32*j -: 32];
    for (int j = 0; j < 16; j++) pend_words[j] = '0;
    pend_fill = '0;
    msg_bits = '0;
  endtask

  task automatic predict_digest(input msg_item_t it);
    logic [31:0] blk[16];
    int wi, sh;
    if (it.func == 2'd3) return;
    if (it.func != FUNC_FINISH) begin
      wi = pend_fill >> 2;
      sh = (3 - pend_fill[1:0]) * 8;
      if (pend_fill[1:0] == 0) pend_words[wi] = '0;
      pend_words[wi] |= 32'(it.data) << sh;
      msg_bits += 64'd8;
      pend_fill = pend_fill + 6'd1;
      if (pend_fill == 0) compress(pend_words);
    end
    if (it.func == FUNC_ABSORB) return;
    wi = pend_fill >> 2;
    sh = (3 - pend_fill[1:0]) * 8;
    for (int j = 0; j < 16; j++) blk[j] = (j < wi) ? pend_words[j] : '0;
    if (sh < 24) blk[wi] = pend_words[wi] & ~((32'd1 << (sh + 8)) - 1);
    blk[wi] |= 32'h80 << sh;
    if (pend_fill >= 56) begin
      compress(blk);
      for (int j = 0; j < 16; j++) blk[j] = '0;
    end
    blk[14] = msg_bits[63:32];
    blk[15] = msg_bits[31:0];
    compress(blk);
    for (int j = 0; j < 8; j++) digest_queue.push_back('{hash_state[j], 3'(j), j == 7});
    clear_hash();
  endtask

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    errors++;
    $display("mismatch %s: got %h expected %h (word %0d)", what, got, want, words_seen);
  endtask

  // driver: predict on acceptance, then present the next word
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_digest('{s_axis_tuser, s_axis_tdata});
        void'(byte_queue.pop_front());
      end
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if ((s_axis_tvalid && !s_axis_tready) ||
                   (!s_axis_tvalid && byte_queue.size() > 0)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= byte_queue[0].data;
        s_axis_tuser  <= byte_queue[0].func;
      end else if (s_axis_tvalid && byte_queue.size() > 0) begin
        // accepted word already dropped from the queue: head is the next one
        if (!quiet && $urandom_range(0, 5) == 0) begin
          send_gap <= $urandom_range(0, 7);
          s_axis_tvalid <= 1'b0;
        end else begin
          s_axis_tdata <= byte_queue[0].data;
          s_axis_tuser <= byte_queue[0].func;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // monitor and sink
  always @(posedge clk) begin
    digest_beat_t got, want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{m_axis_tdata[31:0], m_axis_tdata[34:32], m_axis_tlast};
        if (digest_queue.size() == 0) begin
          report("unexpected word", 64'(got), '0);
        end else begin
          want = digest_queue.pop_front();
          if (got.word != want.word) report("digest_word", 64'(got.word), 64'(want.word));
          if (got.index != want.index) report("word_index", 64'(got.index), 64'(want.index));
          if (got.last != want.last) report("tlast", 64'(got.last), 64'(want.last));
          if (m_axis_tdata[39:35] != 0) report("zero fill", 64'(m_axis_tdata), 0);
        end
        words_seen++;
      end
      if (pressure_on && hold_cycles < 400) begin
        hold_cycles <= hold_cycles + 1;
        m_axis_tready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap <= sink_gap - 1;
        m_axis_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 6) == 0) begin
        sink_gap <= $urandom_range(0, 7);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic add_msg(input int len, input bit fold_last);
    for (int i = 0; i < len; i++) begin
      if (fold_last && i == len - 1)
        byte_queue.push_back('{FUNC_ABSORB_FINISH, 8'($urandom)});
      else
        byte_queue.push_back('{FUNC_ABSORB, 8'($urandom)});
    end
    if (!fold_last || len == 0) byte_queue.push_back('{FUNC_FINISH, 8'($urandom)});
  endtask

  task automatic drain();
    while (byte_queue.size() > 0 || s_axis_tvalid) @(posedge clk);
    while (digest_queue.size() > 0) @(posedge clk);
  endtask

  initial begin
    int len;
    rst = 1'b1;
    clear_hash();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    // empty message, "abc", unused selector, extremes
    add_msg(0, 0);
    byte_queue.push_back('{2'd3, 8'hFF});
    byte_queue.push_back('{FUNC_ABSORB, 8'h61});
    byte_queue.push_back('{FUNC_ABSORB, 8'h62});
    byte_queue.push_back('{FUNC_ABSORB_FINISH, 8'h63});
    byte_queue.push_back('{FUNC_ABSORB, 8'h00});
    byte_queue.push_back('{FUNC_ABSORB, 8'hFF});
    byte_queue.push_back('{FUNC_ABSORB_FINISH, 8'hA5});
    byte_queue.push_back('{FUNC_FINISH, 8'h5A});
    drain();
    // sender waits here until every digest word is back
    pressure_on = 1;
    add_msg(1, 1);
    add_msg(2, 0);
    add_msg(3, 1);
    drain();
    pressure_on = 0;
    // one full absorbed block, then a 56-byte tail that spills into two blocks
    add_msg(120, 1);
    drain();
    // random short messages, a few ignored words mixed in
    for (int m = 0; m < 4; m++) begin
      len = $urandom_range(0, 4);
      if ($urandom_range(0, 2) == 0) byte_queue.push_back('{2'd3, 8'($urandom)});
      add_msg(len, $urandom_range(0, 1));
      if (m == 1) begin
        drain();
        quiet = 1;
      end
    end
    drain();
    repeat (200) @(posedge clk);
    if (digest_queue.size() > 0) begin
      errors++;
      $display("%0d digest words never arrived", digest_queue.size());
    end
    $display("covered empty, single-block and two-block padding tails, ignored selectors,");
    $display("%0d digest words checked under random and long output stalls", words_seen);
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
